### rtl/core/bthin_pkg.sv
// ---------------------------------------------------------------------------
// bthin_pkg
// Shared types, operation codes and the delete table of the binary image
// thinning unit.
// ---------------------------------------------------------------------------
package bthin_pkg;

    // 3x3 window: bits 8..6 row above, 5..3 own row, 2..0 row below.
    typedef logic [8:0] t_win;

    localparam logic [7:0]  BACKGROUND = 8'd255;
    localparam logic [16:0] COUNT_MAX  = 17'd131071;

    // Request kinds carried in tuser.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_PASSES = 2'd2;

    // Gating neighbours: north, south, west, east.
    localparam t_win GATE_N = 9'o200;
    localparam t_win GATE_S = 9'o002;
    localparam t_win GATE_W = 9'o040;
    localparam t_win GATE_E = 9'o010;

    localparam logic [7:0] PASSES_RESET = 8'd20;

    // Delete table, entry 0 in the leftmost bit.
    localparam logic [0:511] DEL_ROM = {
        16'b0000000000000000, 16'b0001001101110011,
        16'b0000000000000000, 16'b0011101100110011,
        16'b0000000000000000, 16'b0000000011110011,
        16'b0000000000000000, 16'b0000000000110011,
        16'b0000000000000000, 16'b0000000011110011,
        16'b0000000000000000, 16'b1011101111111111,
        16'b0000000000000000, 16'b1000000011110011,
        16'b0000000000000000, 16'b1011101111111111,
        16'b0000000000000000, 16'b0000000000000000,
        16'b0000000000000000, 16'b1011101100110011,
        16'b0000000000000000, 16'b0000000000000000,
        16'b0000000000000000, 16'b0000000000110011,
        16'b0000000000000000, 16'b1000000011110011,
        16'b0000000000000000, 16'b1011101111111111,
        16'b0000000000000000, 16'b1000000011110011,
        16'b0000000000000000, 16'b1011101111111111
    };

    // Gate mask of one subiteration.
    function automatic t_win gate_of(input logic [1:0] sub);
        t_win g;
        case (sub)
            2'd0: g = GATE_N;
            2'd1: g = GATE_S;
            2'd2: g = GATE_W;
            default: g = GATE_E;
        endcase
        return g;
    endfunction

endpackage

### rtl/core/binary_image_thinning_unit.sv
// ---------------------------------------------------------------------------
// binary_image_thinning_unit
// Pixel store with in-place table-driven thinning over a raster scan.
// ---------------------------------------------------------------------------
// A pixel write goes into the image memory as it is taken; a read delivers its
// result through the registered image read port and the output register and holds
// the input off meanwhile. A start holds the input off until its run report; with H
// and W clamped, every subiteration scans (H+1)*(W+1) positions, then drains.
// Reset (synchronous, active low) clears control and statistics and loads the size
// and pass registers with 256, 256 and 20; image memory and row buffer stay as is.
module binary_image_thinning_unit
    import bthin_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // column[7:0], row[15:8], pixel_in[23:16]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // pixel_out[7:0], passes_done[15:8],
                                        // removed_count[32:16], zero[39:33]
    output logic [0:0]  m_axis_tuser,   // is_run_report[0]
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int AW    = CW + RW;
    localparam int DEPTH = 1 << AW;
    localparam int LBD   = 1 << CW;
    localparam int SCW   = CW + 1;
    localparam int SRW   = RW + 1;
    localparam int PCW   = $clog2(4 * MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SUMW  = ((PCW > 17) ? PCW : 17) + 1;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_READ    = 3'd1;
    localparam logic [2:0] ST_SCAN    = 3'd2;
    localparam logic [2:0] ST_DRAIN   = 3'd3;
    localparam logic [2:0] ST_SUBEND  = 3'd4;
    localparam logic [2:0] ST_PASSEND = 3'd5;
    localparam logic [2:0] ST_REPORT  = 3'd6;

    logic [2:0]     r_state;
    logic [8:0]     r_cfg_w;
    logic [8:0]     r_cfg_h;
    logic [7:0]     r_cfg_max;
    logic [7:0]     r_last_pass;
    logic [16:0]    r_last_total;
    logic [PCW-1:0] r_pass_rm;
    logic [1:0]     r_sub;
    logic [SRW-1:0] r_sr;
    logic [SCW-1:0] r_sc;
    logic           r_rd_out;

    // Scan pipeline stage
    logic           r_p_v;
    logic [SRW-1:0] r_p_r;
    logic [SCW-1:0] r_p_c;
    logic [2:0]     r_wa;
    logic [2:0]     r_wb;

    // Memories and their read registers
    logic [7:0]     mem [DEPTH];
    logic [1:0]     lbuf [LBD];
    logic [7:0]     r_mem_q;
    logic [1:0]     r_lb_q;

    // Output register
    logic           r_o_valid;
    logic [7:0]     r_o_pix;
    logic [7:0]     r_o_pass;
    logic [16:0]    r_o_rm;
    logic           r_o_user;

    logic [7:0]     in_col;
    logic [7:0]     in_row;
    logic [7:0]     in_pix;
    logic [1:0]     in_op;
    logic           in_acc;
    logic           in_inside;
    logic [AW-1:0]  in_addr;
    logic [SCW-1:0] w_eff;
    logic [SRW-1:0] h_eff;
    logic           scan_in;
    logic [AW-1:0]  sc_addr;
    logic           p_in_c;
    logic           p_fg;
    logic           p_top;
    logic           p_mid;
    logic [2:0]     p_col;
    t_win           win;
    logic           do_del;
    logic [AW-1:0]  del_addr;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    logic [7:0]     mem_wd;
    logic           mem_re;
    logic [AW-1:0]  mem_ra;
    logic [7:0]     passes_n;
    logic [SUMW-1:0] sum;
    logic [16:0]    sum_sat;

    // Request fields and handshakes
    assign in_col        = s_axis_tdata[7:0];
    assign in_row        = s_axis_tdata[15:8];
    assign in_pix        = s_axis_tdata[23:16];
    assign in_op         = s_axis_tuser;
    assign s_axis_tready = (r_state == ST_IDLE) && (!r_o_valid || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign in_inside     = (int'(in_col) < MAX_WIDTH) && (int'(in_row) < MAX_HEIGHT);
    assign in_addr       = (AW'(in_row) << CW) | AW'(in_col);

    // Image size clamped to the store
    assign w_eff = (int'(r_cfg_w) > MAX_WIDTH)  ? SCW'(MAX_WIDTH)  : SCW'(r_cfg_w);
    assign h_eff = (int'(r_cfg_h) > MAX_HEIGHT) ? SRW'(MAX_HEIGHT) : SRW'(r_cfg_h);

    // Scan position issued this cycle
    assign scan_in = (r_sr < h_eff) && (r_sc < w_eff);
    assign sc_addr = (AW'(r_sr[RW-1:0]) << CW) | AW'(r_sc[CW-1:0]);

    // Column vector of the position read last cycle, with outside pixels as background.
    assign p_in_c = r_p_c < w_eff;
    assign p_fg   = (r_p_r < h_eff) && p_in_c && (r_mem_q != BACKGROUND);
    assign p_top  = (r_p_r >= SRW'(2)) && r_lb_q[1];
    assign p_mid  = (r_p_r >= SRW'(1)) && r_lb_q[0];
    assign p_col  = p_in_c ? {p_top, p_mid, p_fg} : 3'b000;
    assign win    = {r_wa[2], r_wb[2], p_col[2], r_wa[1], r_wb[1], p_col[1],
                     r_wa[0], r_wb[0], p_col[0]};

    // Delete decision for the window centre one row up and one column left.
    assign do_del   = r_p_v && (r_p_r != '0) && (r_p_c != '0) &&
                      ((win & gate_of(r_sub)) == '0) && DEL_ROM[win];
    assign del_addr = (AW'(r_p_r - SRW'(1)) << CW) | AW'(r_p_c - SCW'(1));

    // Memory port selection
    always_comb begin
        mem_we = 1'b0;
        mem_wa = in_addr;
        mem_wd = in_pix;
        if (do_del) begin
            mem_we = 1'b1;
            mem_wa = del_addr;
            mem_wd = BACKGROUND;
        end else if (in_acc && (in_op == OP_WRITE) && in_inside) begin
            mem_we = 1'b1;
        end
        mem_re = (r_state == ST_SCAN) ? scan_in :
                 (in_acc && (in_op == OP_READ) && in_inside);
        mem_ra = (r_state == ST_SCAN) ? sc_addr : in_addr;
    end

    // Image memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q <= mem[mem_ra];
        end
    end

    // Row buffer: foreground bits of the two rows above, before removals.
    always_ff @(posedge i_clk) begin
        if (r_p_v && p_in_c) begin
            lbuf[r_p_c[CW-1:0]] <= {p_mid, p_fg};
        end
        if ((r_state == ST_SCAN) && (r_sc < w_eff)) begin
            r_lb_q <= lbuf[r_sc[CW-1:0]];
        end
    end

    // Pass statistics
    assign passes_n = r_last_pass + 8'd1;
    assign sum      = SUMW'(r_last_total) + SUMW'(r_pass_rm);
    assign sum_sat  = (sum > SUMW'(COUNT_MAX)) ? COUNT_MAX : sum[16:0];

    // Window columns and pipeline payload
    always_ff @(posedge i_clk) begin
        r_p_r <= r_sr;
        r_p_c <= r_sc;
        if (r_p_v) begin
            if (r_p_c == '0) begin
                r_wa <= 3'b000;
            end else begin
                r_wa <= r_wb;
            end
            r_wb <= p_col;
        end
    end

    // Sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cfg_w      <= 9'd256;
            r_cfg_h      <= 9'd256;
            r_cfg_max    <= PASSES_RESET;
            r_last_pass  <= '0;
            r_last_total <= '0;
            r_pass_rm    <= '0;
            r_sub        <= '0;
            r_sr         <= '0;
            r_sc         <= '0;
            r_p_v        <= 1'b0;
            r_o_valid    <= 1'b0;
            r_rd_out     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WIDTH:  r_cfg_w   <= i_cfg_data;
                    CFG_HEIGHT: r_cfg_h   <= i_cfg_data;
                    CFG_PASSES: r_cfg_max <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            r_p_v <= (r_state == ST_SCAN);
            if (do_del) begin
                r_pass_rm <= r_pass_rm + PCW'(1);
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        case (in_op)
                            OP_START: begin
                                r_last_pass  <= '0;
                                r_last_total <= '0;
                                r_pass_rm    <= '0;
                                r_sub        <= '0;
                                r_sr         <= '0;
                                r_sc         <= '0;
                                r_state      <= (r_cfg_max == '0) ? ST_REPORT : ST_SCAN;
                            end
                            OP_READ: begin
                                r_rd_out <= !in_inside;
                                r_state  <= ST_READ;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_READ: begin
                    r_o_pix   <= r_rd_out ? BACKGROUND : r_mem_q;
                    r_o_pass  <= r_last_pass;
                    r_o_rm    <= r_last_total;
                    r_o_user  <= 1'b0;
                    r_o_valid <= 1'b1;
                    r_state   <= ST_IDLE;
                end
                ST_SCAN: begin
                    if (r_sc == w_eff) begin
                        r_sc <= '0;
                        if (r_sr == h_eff) begin
                            r_state <= ST_DRAIN;
                        end else begin
                            r_sr <= r_sr + SRW'(1);
                        end
                    end else begin
                        r_sc <= r_sc + SCW'(1);
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_SUBEND;
                end
                ST_SUBEND: begin
                    if (r_sub == 2'd3) begin
                        r_state <= ST_PASSEND;
                    end else begin
                        r_sub   <= r_sub + 2'd1;
                        r_sr    <= '0;
                        r_sc    <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_PASSEND: begin
                    r_last_pass  <= passes_n;
                    r_last_total <= sum_sat;
                    r_pass_rm    <= '0;
                    r_sub        <= '0;
                    r_sr         <= '0;
                    r_sc         <= '0;
                    if ((r_pass_rm == '0) || (passes_n == r_cfg_max)) begin
                        r_state <= ST_REPORT;
                    end else begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_REPORT: begin
                    r_o_pix   <= '0;
                    r_o_pass  <= r_last_pass;
                    r_o_rm    <= r_last_total;
                    r_o_user  <= 1'b1;
                    r_o_valid <= 1'b1;
                    r_state   <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {7'd0, r_o_rm, r_o_pass, r_o_pix};
    assign m_axis_tuser  = r_o_user;

    // A removal never targets the pixel being read in the same cycle.
    a_del_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_del |-> !((r_state == ST_SCAN) && scan_in && (sc_addr == del_addr)))
        else $error("removal write collides with scan read");

    // A run report never shows more passes than allowed.
    a_pass_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_user) |-> (r_o_pass <= r_cfg_max))
        else $error("pass count above limit");

    // No request is taken while a read or a thinning run is in progress.
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready)
        else $error("request accepted while busy");

endmodule

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: testbench of the binary image thinning unit
// Loads small and extreme-sized images through pixel write requests, starts
// thinning under several size and pass-limit settings, and reads the image
// back. Each result is checked field by field against fixed values or a
// behavioral thinning predictor with its own copy of image store and registers.
// ---------------------------------------------------------------------------
module tb_top;
    import bthin_pkg::*;

    localparam int WD_LIMIT = 1000000;
    localparam int SETTLE   = 20;

    // Operation code that the block ignores.
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [7:0]  pixel;
        logic [7:0]  passes;
        logic [16:0] removed;
        logic        report;
    } t_result;

    typedef struct {
        logic [1:0] op;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] pix;
        bit         typed;
        t_result    res;
    } t_vec;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [8:0]  i_cfg_data = '0;

    // Predictor state.
    logic [7:0]  pix_mem [0:65535];
    bit          fg_snap [0:65535];
    logic [8:0]  reg_width, reg_height;
    logic [7:0]  reg_passes;
    logic [7:0]  last_passes;
    logic [16:0] last_removed;

    t_result     pending_results[$];
    int          errors = 0;
    int          req_count = 0;
    int          idle_cycles = 0;
    bit          hold_req = 1'b0;
    bit          valid_up = 1'b0;

    binary_image_thinning_unit dut (.*);

    always #4 i_clk = ~i_clk;

    // Thinning of the predictor's image, pass by pass.
    task automatic thin_image();
        int w, h, x, y, dx, dy, k, xx, yy;
        int in_pass, total, passes;
        t_win win, gate;
        w = (reg_width > 256) ? 256 : int'(reg_width);
        h = (reg_height > 256) ? 256 : int'(reg_height);
        passes = 0;
        total = 0;
        while (passes < reg_passes) begin
            passes++;
            in_pass = 0;
            for (k = 0; k < 4; k++) begin
                gate = gate_of(k[1:0]);
                for (y = 0; y < h; y++)
                    for (x = 0; x < w; x++)
                        fg_snap[y*256+x] = (pix_mem[y*256+x] != BACKGROUND);
                for (y = 0; y < h; y++) begin
                    for (x = 0; x < w; x++) begin
                        win = '0;
                        for (dy = -1; dy <= 1; dy++)
                            for (dx = -1; dx <= 1; dx++) begin
                                xx = x + dx;
                                yy = y + dy;
                                if (xx >= 0 && yy >= 0 && xx < w && yy < h &&
                                    fg_snap[yy*256+xx])
                                    win[8 - ((dy+1)*3 + dx + 1)] = 1'b1;
                            end
                        if ((win & gate) == '0 && DEL_ROM[win]) begin
                            pix_mem[y*256+x] = BACKGROUND;
                            in_pass++;
                        end
                    end
                end
            end
            total += in_pass;
            if (total > COUNT_MAX) total = COUNT_MAX;
            if (in_pass == 0) break;
        end
        last_passes = passes[7:0];
        last_removed = total[16:0];
    endtask

    // Applies one accepted request to the predictor and returns its result.
    task automatic thin_model_step(input logic [1:0] op, input logic [7:0] col,
                                   input logic [7:0] row, input logic [7:0] pix,
                                   output bit has_res, output t_result res);
        has_res = 1'b0;
        res = '0;
        case (op)
            OP_WRITE: pix_mem[{row, col}] = pix;
            OP_START: begin
                thin_image();
                has_res = 1'b1;
                res = '{8'd0, last_passes, last_removed, 1'b1};
            end
            OP_READ: begin
                has_res = 1'b1;
                res = '{pix_mem[{row, col}], last_passes, last_removed, 1'b0};
            end
            default: ;
        endcase
    endtask

    // Offers one request after a random gap and waits for its acceptance.
    task automatic send_req(input logic [1:0] op, input logic [7:0] col,
                            input logic [7:0] row, input logic [7:0] pix,
                            input bit typed, input t_result typed_res);
        int gap;
        bit has_res;
        t_result res;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            if (valid_up) s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        valid_up = 1'b1;
        s_axis_tdata <= {pix, row, col};
        s_axis_tuser <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        thin_model_step(op, col, row, pix, has_res, res);
        if (has_res) pending_results.push_back(typed ? typed_res : res);
        req_count++;
    endtask

    task automatic req(input logic [1:0] op, input logic [7:0] col,
                       input logic [7:0] row, input logic [7:0] pix);
        send_req(op, col, row, pix, 1'b0, '0);
    endtask

    // Drops the request valid and waits until the block has gone quiet.
    task automatic wait_quiet();
        if (valid_up) s_axis_tvalid <= 1'b0;
        valid_up = 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [8:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_WIDTH:  reg_width = data;
            CFG_HEIGHT: reg_height = data;
            default:    reg_passes = data[7:0];
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] draw_pixel(input int mode, input int x, input int y,
                                              input int w, input int h);
        bit fg;
        case (mode)
            0: fg = ($urandom_range(0, 9) < 7);
            1: fg = (x > 0 && y > 0 && x < w - 1 && y < h - 1);
            2: fg = 1'b1;
            default: fg = ($urandom_range(0, 9) < 3);
        endcase
        return fg ? 8'($urandom_range(0, 254)) : BACKGROUND;
    endfunction

    // One setting: load the whole image, start, read back, restart once.
    task automatic run_phase(input logic [8:0] w, input logic [8:0] h,
                             input logic [8:0] mp, input int nreads, input bit press);
        int we, he, x, y, i, mode;
        wait_quiet();
        cfg_write(CFG_WIDTH, w);
        cfg_write(CFG_HEIGHT, h);
        cfg_write(CFG_PASSES, mp);
        we = (w > 256) ? 256 : int'(w);
        he = (h > 256) ? 256 : int'(h);
        mode = $urandom_range(0, 3);
        for (y = 0; y < he; y++)
            for (x = 0; x < we; x++) begin
                req(OP_WRITE, x[7:0], y[7:0], draw_pixel(mode, x, y, we, he));
                if ($urandom_range(0, 19) == 0)
                    req(OP_UNKNOWN, 8'($urandom), 8'($urandom), 8'($urandom));
                if ($urandom_range(0, 9) == 0)
                    req(OP_READ, 8'($urandom_range(0, x)), y[7:0], 8'($urandom));
            end
        req(OP_START, 8'($urandom), 8'($urandom), 8'($urandom));
        if (press) hold_req = 1'b1;
        if (we > 0 && he > 0) begin
            for (i = 0; i < nreads; i++)
                req(OP_READ, 8'($urandom_range(0, we - 1)),
                    8'($urandom_range(0, he - 1)), 8'($urandom));
            for (i = 0; i < 3; i++)
                req(OP_WRITE, 8'($urandom_range(0, we - 1)),
                    8'($urandom_range(0, he - 1)), 8'($urandom));
        end
        req(OP_START, 8'($urandom), 8'($urandom), 8'($urandom));
        if (we > 0 && he > 0)
            req(OP_READ, 8'($urandom_range(0, we - 1)),
                8'($urandom_range(0, he - 1)), 8'($urandom));
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[32:16],
                    m_axis_tuser[0]};
            if (pending_results.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.pixel !== want.pixel) begin
                    $error("pixel_out exp %0d got %0d", want.pixel, got.pixel);
                    errors++;
                end
                if (got.passes !== want.passes) begin
                    $error("passes_done exp %0d got %0d", want.passes, got.passes);
                    errors++;
                end
                if (got.removed !== want.removed) begin
                    $error("removed_count exp %0d got %0d", want.removed, got.removed);
                    errors++;
                end
                if (got.report !== want.report) begin
                    $error("is_run_report exp %0d got %0d", want.report, got.report);
                    errors++;
                end
            end
        end
    end

    // Result receiver with random stalls and one long hold-off.
    initial begin
        int stall;
        forever begin
            stall = $urandom_range(0, 5);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (hold_req) begin
                stall = 300;
                hold_req = 1'b0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // Watchdog over cycles with no accepted request, result or register write.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Main sequence.
    initial begin
        t_vec dir_vecs[$];
        reg_width = 9'd256;
        reg_height = 9'd256;
        reg_passes = PASSES_RESET;
        last_passes = '0;
        last_removed = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on a 3x3 image.
        dir_vecs.push_back('{OP_WRITE, 8'd0, 8'd0, 8'd0, 1'b0, '0});
        dir_vecs.push_back('{OP_READ, 8'd0, 8'd0, 8'd77, 1'b1, '{8'd0, 8'd0, 17'd0, 1'b0}});
        dir_vecs.push_back('{OP_WRITE, 8'd255, 8'd255, 8'd255, 1'b0, '0});
        dir_vecs.push_back('{OP_READ, 8'd255, 8'd255, 8'd0,
                             1'b1, '{8'd255, 8'd0, 17'd0, 1'b0}});
        dir_vecs.push_back('{OP_WRITE, 8'd255, 8'd0, 8'd128, 1'b0, '0});
        dir_vecs.push_back('{OP_READ, 8'd255, 8'd0, 8'd0, 1'b0, '0});
        dir_vecs.push_back('{OP_UNKNOWN, 8'd255, 8'd255, 8'd255, 1'b0, '0});
        dir_vecs.push_back('{OP_WRITE, 8'd1, 8'd0, 8'd254, 1'b0, '0});
        dir_vecs.push_back('{OP_WRITE, 8'd2, 8'd0, 8'd1, 1'b0, '0});
        dir_vecs.push_back('{OP_WRITE, 8'd0, 8'd1, 8'd10, 1'b0, '0});
        dir_vecs.push_back('{OP_WRITE, 8'd1, 8'd1, 8'd20, 1'b0, '0});
        dir_vecs.push_back('{OP_WRITE, 8'd2, 8'd1, 8'd30, 1'b0, '0});
        dir_vecs.push_back('{OP_WRITE, 8'd0, 8'd2, 8'd255, 1'b0, '0});
        dir_vecs.push_back('{OP_WRITE, 8'd1, 8'd2, 8'd40, 1'b0, '0});
        dir_vecs.push_back('{OP_WRITE, 8'd2, 8'd2, 8'd50, 1'b0, '0});
        dir_vecs.push_back('{OP_START, 8'd0, 8'd0, 8'd0, 1'b0, '0});
        dir_vecs.push_back('{OP_READ, 8'd1, 8'd1, 8'd0, 1'b0, '0});
        dir_vecs.push_back('{OP_READ, 8'd2, 8'd0, 8'd0, 1'b0, '0});
        dir_vecs.push_back('{OP_START, 8'd0, 8'd0, 8'd0, 1'b0, '0});
        dir_vecs.push_back('{OP_READ, 8'd0, 8'd0, 8'd0, 1'b0, '0});
        cfg_write(CFG_WIDTH, 9'd3);
        cfg_write(CFG_HEIGHT, 9'd3);
        cfg_write(CFG_PASSES, 9'd20);
        foreach (dir_vecs[i])
            send_req(dir_vecs[i].op, dir_vecs[i].col, dir_vecs[i].row, dir_vecs[i].pix,
                     dir_vecs[i].typed, dir_vecs[i].res);

        // Extreme settings: widest, tallest, saturated, empty and pass limits.
        run_phase(9'd256, 9'd2, 9'd20, 20, 1'b0);
        run_phase(9'd1, 9'd256, 9'd20, 20, 1'b0);
        run_phase(9'd300, 9'd1, 9'd20, 10, 1'b0);
        run_phase(9'd1, 9'd511, 9'd3, 10, 1'b0);
        run_phase(9'd0, 9'd4, 9'd5, 0, 1'b0);
        run_phase(9'd5, 9'd0, 9'd5, 0, 1'b0);
        run_phase(9'd4, 9'd4, 9'd0, 8, 1'b0);
        run_phase(9'd6, 9'd6, 9'd1, 40, 1'b1);
        run_phase(9'd8, 9'd8, 9'd255, 20, 1'b0);

        // Random settings on small images.
        while (req_count < 1900)
            run_phase(9'($urandom_range(1, 12)), 9'($urandom_range(1, 12)),
                      ($urandom_range(0, 4) == 0) ? 9'($urandom_range(1, 255))
                                                  : 9'($urandom_range(1, 12)),
                      $urandom_range(5, 30), 1'b0);

        wait_quiet();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
